### src/amm_pkg.sv
package amm_pkg;

  localparam int DEF_MAX_STATES   = 256;
  localparam int DEF_MAX_PATTERNS = 64;

  localparam int SYM_W    = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int REACH_W  = 8;
  localparam int PNUM_W   = 6;

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_END     = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  // Handshake back from the edge search unit.
  typedef struct packed {
    logic done;
    logic found;
  } srch_rsp_t;

endpackage

### src/amm_edge_search.sv
module amm_edge_search import amm_pkg::*; #(
  parameter int MAX_STATES = DEF_MAX_STATES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [$clog2(MAX_STATES)-1:0] start_parent,
  input  logic [SYM_W-1:0]              start_sym,
  input  logic [$clog2(MAX_STATES+1)-1:0] state_count,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_STATES)-1:0] wr_addr,
  input  logic [$clog2(MAX_STATES)-1:0] wr_parent,
  input  logic [SYM_W-1:0]              wr_sym,
  output srch_rsp_t                     rsp,
  output logic [$clog2(MAX_STATES)-1:0] child
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int CW = $clog2(MAX_STATES+1);
  localparam int EW = SW + SYM_W;

  logic [EW-1:0] edge_mem [MAX_STATES];

  logic          busy_r;
  logic          pend_r;
  logic [CW-1:0] idx_r;
  logic [SW-1:0] pend_idx_r;
  logic [EW-1:0] rd_data_r;
  logic [SW-1:0] parent_r;
  logic [SYM_W-1:0] sym_r;

  logic hit;
  logic issue;
  logic done;

  // One stored edge is read per cycle into a register and compared against the key in the cycle after.
  assign hit   = pend_r && (rd_data_r == {parent_r, sym_r});
  assign issue = busy_r && !hit && (idx_r < state_count);
  assign done  = busy_r && (hit || (!pend_r && (idx_r >= state_count)));

  assign rsp.done  = done;
  assign rsp.found = hit;
  assign child     = pend_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      pend_r <= 1'b0;
    end else if (busy_r) begin
      if (done) begin
        busy_r <= 1'b0;
        pend_r <= 1'b0;
      end else begin
        pend_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r    <= CW'(1);
      parent_r <= start_parent;
      sym_r    <= start_sym;
    end else if (issue) begin
      idx_r <= idx_r + CW'(1);
    end
    if (issue) begin
      pend_idx_r <= idx_r[SW-1:0];
      rd_data_r  <= edge_mem[idx_r[SW-1:0]];
    end
    if (wr_en) begin
      edge_mem[wr_addr] <= {wr_parent, wr_sym};
    end
  end

endmodule

### src/amm_node_store.sv
module amm_node_store import amm_pkg::*; #(
  parameter int MAX_STATES   = DEF_MAX_STATES,
  parameter int MAX_PATTERNS = DEF_MAX_PATTERNS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fl_wr_en,
  input  logic [$clog2(MAX_STATES)-1:0]   fl_wr_addr,
  input  logic [$clog2(MAX_STATES)-1:0]   fl_wr_data,
  input  logic                            fl_rd_en,
  input  logic [$clog2(MAX_STATES)-1:0]   fl_rd_addr,
  output logic [$clog2(MAX_STATES)-1:0]   fl_rd_data,
  input  logic                            mk_wr_en,
  input  logic [$clog2(MAX_STATES)-1:0]   mk_wr_addr,
  input  logic                            mk_wr_valid,
  input  logic [$clog2(MAX_PATTERNS+1)-1:0] mk_wr_num,
  input  logic                            mk_rd_en,
  input  logic [$clog2(MAX_STATES)-1:0]   mk_rd_addr,
  output logic                            mk_rd_valid,
  output logic [$clog2(MAX_PATTERNS+1)-1:0] mk_rd_num
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int PW = $clog2(MAX_PATTERNS+1);

  logic [SW-1:0] fail_mem [MAX_STATES];
  logic [PW:0]   mark_mem [MAX_STATES];

  logic [SW-1:0] fl_data_r;
  logic [PW:0]   mk_data_r;
  logic          mk_root_r;
  logic          root_valid_r;
  logic [PW-1:0] root_num_r;

  assign fl_rd_data  = fl_data_r;
  // The root exists from reset, so its mark lives in flip-flops; every other
  // entry is written invalid when its state is created.
  assign mk_rd_valid = mk_root_r ? root_valid_r : mk_data_r[PW];
  assign mk_rd_num   = mk_root_r ? root_num_r : mk_data_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_valid_r <= 1'b0;
    end else if (mk_wr_en && (mk_wr_addr == '0)) begin
      root_valid_r <= mk_wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mk_wr_en && (mk_wr_addr == '0)) begin
      root_num_r <= mk_wr_num;
    end
    if (mk_wr_en) begin
      mark_mem[mk_wr_addr] <= {mk_wr_valid, mk_wr_num};
    end
    if (mk_rd_en) begin
      mk_data_r <= mark_mem[mk_rd_addr];
      mk_root_r <= (mk_rd_addr == '0);
    end
    if (fl_wr_en) begin
      fail_mem[fl_wr_addr] <= fl_wr_data;
    end
    if (fl_rd_en) begin
      fl_data_r <= fail_mem[fl_rd_addr];
    end
  end

endmodule

### src/multi_pattern_automaton_matcher_top.sv
// Sequencing: end pattern and restart go through S_DONE to the output register; a scan
// runs edge searches and then reads the mark in S_MARK, and an add runs edge searches,
// with one search per failure-link hop and, for an add, one more on the cursor.
// Throughput: one item at a time; the edge search unit reads one stored edge per cycle,
// so cost grows with the number of states times the failure-link chain length.
// Reset: synchronous, active low; the automaton returns to the root alone, no clearing pass.
module multi_pattern_automaton_matcher_top import amm_pkg::*; #(
  parameter int MAX_STATES   = DEF_MAX_STATES,
  parameter int MAX_PATTERNS = DEF_MAX_PATTERNS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [SYM_W-1:0]    in_symbol,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [REACH_W-1:0]  out_reached_state,
  output logic                out_match_found,
  output logic [PNUM_W-1:0]   out_pattern_number
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int CW = $clog2(MAX_STATES+1);
  localparam int PW = $clog2(MAX_PATTERNS+1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BSRCH = 3'd1;
  localparam logic [2:0] S_BLINK = 3'd2;
  localparam logic [2:0] S_HSRCH = 3'd3;
  localparam logic [2:0] S_HLINK = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] cursor_r, cursor_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] pat_r, pat_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]  op_r, op_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic [SW-1:0]    ns_r, ns_nxt;
  logic [SW-1:0]    st_r, st_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [REACH_W-1:0]  res_reach_r, res_reach_nxt;
  logic                res_match_r, res_match_nxt;
  logic [PW-1:0]       res_num_r, res_num_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [REACH_W-1:0]  out_reach_r, out_reach_nxt;
  logic                out_match_r, out_match_nxt;
  logic [PNUM_W-1:0]   out_num_r, out_num_nxt;

  logic          srch_start;
  logic [SW-1:0] srch_parent;
  logic [SYM_W-1:0] srch_sym;
  srch_rsp_t     srch_rsp;
  logic [SW-1:0] srch_child;
  logic          edge_wr_en;

  logic          fl_wr_en, fl_rd_en;
  logic [SW-1:0] fl_wr_addr, fl_wr_data, fl_rd_addr, fl_rd_data;
  logic          mk_wr_en, mk_wr_valid, mk_rd_en, mk_rd_valid;
  logic [SW-1:0] mk_wr_addr, mk_rd_addr;
  logic [PW-1:0] mk_wr_num, mk_rd_num;

  logic          hop_end;
  logic [SW-1:0] hop_state;

  amm_edge_search #(
    .MAX_STATES(MAX_STATES)
  ) u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (srch_start),
    .start_parent (srch_parent),
    .start_sym    (srch_sym),
    .state_count  (count_r),
    .wr_en        (edge_wr_en),
    .wr_addr      (count_r[SW-1:0]),
    .wr_parent    (cursor_r),
    .wr_sym       (sym_r),
    .rsp          (srch_rsp),
    .child        (srch_child)
  );

  amm_node_store #(
    .MAX_STATES   (MAX_STATES),
    .MAX_PATTERNS (MAX_PATTERNS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .fl_wr_en    (fl_wr_en),
    .fl_wr_addr  (fl_wr_addr),
    .fl_wr_data  (fl_wr_data),
    .fl_rd_en    (fl_rd_en),
    .fl_rd_addr  (fl_rd_addr),
    .fl_rd_data  (fl_rd_data),
    .mk_wr_en    (mk_wr_en),
    .mk_wr_addr  (mk_wr_addr),
    .mk_wr_valid (mk_wr_valid),
    .mk_wr_num   (mk_wr_num),
    .mk_rd_en    (mk_rd_en),
    .mk_rd_addr  (mk_rd_addr),
    .mk_rd_valid (mk_rd_valid),
    .mk_rd_num   (mk_rd_num)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_reached_state  = out_reach_r;
  assign out_match_found    = out_match_r;
  assign out_pattern_number = out_num_r;

  // A hop ends on a hit, or at the root whose link leads nowhere.
  assign hop_end   = srch_rsp.done && (srch_rsp.found || (st_r == '0));
  assign hop_state = srch_rsp.found ? srch_child : '0;

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    scan_nxt       = scan_r;
    count_nxt      = count_r;
    pat_nxt        = pat_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    sym_nxt        = sym_r;
    ns_nxt         = ns_r;
    st_nxt         = st_r;
    res_status_nxt = res_status_r;
    res_reach_nxt  = res_reach_r;
    res_match_nxt  = res_match_r;
    res_num_nxt    = res_num_r;
    out_status_nxt = out_status_r;
    out_reach_nxt  = out_reach_r;
    out_match_nxt  = out_match_r;
    out_num_nxt    = out_num_r;
    srch_start     = 1'b0;
    srch_parent    = cursor_r;
    srch_sym       = sym_r;
    edge_wr_en     = 1'b0;
    fl_wr_en       = 1'b0;
    fl_wr_addr     = ns_r;
    fl_wr_data     = hop_state;
    fl_rd_en       = 1'b0;
    fl_rd_addr     = cursor_r;
    mk_wr_en       = 1'b0;
    mk_wr_addr     = cursor_r;
    mk_wr_valid    = 1'b1;
    mk_wr_num      = pat_r;
    mk_rd_en       = 1'b0;
    mk_rd_addr     = hop_state;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          sym_nxt        = in_symbol;
          res_status_nxt = ST_OK;
          res_match_nxt  = 1'b0;
          res_num_nxt    = '0;
          unique case (in_operation)
            OP_ADD: begin
              srch_start  = 1'b1;
              srch_parent = cursor_r;
              srch_sym    = in_symbol;
              state_nxt   = S_BSRCH;
            end
            OP_END: begin
              if (pat_r >= PW'(MAX_PATTERNS)) begin
                res_status_nxt = ST_EXHAUSTED;
                res_reach_nxt  = REACH_W'(cursor_r);
              end else begin
                mk_wr_en      = 1'b1;
                pat_nxt       = pat_r + PW'(1);
                cursor_nxt    = '0;
                res_reach_nxt = '0;
              end
              state_nxt = S_DONE;
            end
            OP_SCAN: begin
              st_nxt      = scan_r;
              srch_start  = 1'b1;
              srch_parent = scan_r;
              srch_sym    = in_symbol;
              state_nxt   = S_HSRCH;
            end
            default: begin
              scan_nxt      = '0;
              res_reach_nxt = '0;
              state_nxt     = S_DONE;
            end
          endcase
        end
      end
      S_BSRCH: begin
        if (srch_rsp.done) begin
          if (srch_rsp.found) begin
            cursor_nxt    = srch_child;
            res_reach_nxt = REACH_W'(srch_child);
            state_nxt     = S_DONE;
          end else if (count_r >= CW'(MAX_STATES)) begin
            res_status_nxt = ST_FULL;
            res_reach_nxt  = REACH_W'(cursor_r);
            state_nxt      = S_DONE;
          end else begin
            // Create the new state; its mark starts out clear.
            edge_wr_en    = 1'b1;
            mk_wr_en      = 1'b1;
            mk_wr_addr    = count_r[SW-1:0];
            mk_wr_valid   = 1'b0;
            count_nxt     = count_r + CW'(1);
            ns_nxt        = count_r[SW-1:0];
            cursor_nxt    = count_r[SW-1:0];
            res_reach_nxt = REACH_W'(count_r[SW-1:0]);
            if (cursor_r == '0) begin
              fl_wr_en   = 1'b1;
              fl_wr_addr = count_r[SW-1:0];
              fl_wr_data = '0;
              state_nxt  = S_DONE;
            end else begin
              fl_rd_en   = 1'b1;
              fl_rd_addr = cursor_r;
              state_nxt  = S_BLINK;
            end
          end
        end
      end
      S_BLINK, S_HLINK: begin
        st_nxt      = fl_rd_data;
        srch_start  = 1'b1;
        srch_parent = fl_rd_data;
        srch_sym    = sym_r;
        state_nxt   = S_HSRCH;
      end
      S_HSRCH: begin
        if (hop_end) begin
          if (op_r == OP_ADD) begin
            fl_wr_en  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            scan_nxt      = hop_state;
            mk_rd_en      = 1'b1;
            res_reach_nxt = REACH_W'(hop_state);
            state_nxt     = S_MARK;
          end
        end else if (srch_rsp.done) begin
          fl_rd_en   = 1'b1;
          fl_rd_addr = st_r;
          state_nxt  = S_HLINK;
        end
      end
      S_MARK: begin
        res_match_nxt = mk_rd_valid;
        res_num_nxt   = mk_rd_valid ? mk_rd_num : '0;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_reach_nxt  = res_reach_r;
          out_match_nxt  = res_match_r;
          out_num_nxt    = PNUM_W'(res_num_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      scan_r      <= '0;
      count_r     <= CW'(1);
      pat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      scan_r      <= scan_nxt;
      count_r     <= count_nxt;
      pat_r       <= pat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sym_r        <= sym_nxt;
    ns_r         <= ns_nxt;
    st_r         <= st_nxt;
    res_status_r <= res_status_nxt;
    res_reach_r  <= res_reach_nxt;
    res_match_r  <= res_match_nxt;
    res_num_r    <= res_num_nxt;
    out_status_r <= out_status_nxt;
    out_reach_r  <= out_reach_nxt;
    out_match_r  <= out_match_nxt;
    out_num_r    <= out_num_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_found) |-> (out_status == ST_OK))
    else $error("match reported with error status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(MAX_STATES)))
    else $error("state count out of range");

  a_search_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !srch_rsp.done)
    else $error("edge search finished while idle");
`endif

endmodule

### verif/multi_pattern_automaton_matcher_top_tb.sv
`timescale 1ns / 100ps

module multi_pattern_automaton_matcher_top_tb;
  import amm_pkg::*;

  localparam int NSTATES   = DEF_MAX_STATES;
  localparam int NPATTERNS = DEF_MAX_PATTERNS;
  localparam int STUCK_LIMIT = 400000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] sym;
  } item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [REACH_W-1:0]  reached;
    logic                found;
    logic [PNUM_W-1:0]   pnum;
  } match_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = OP_RESTART;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [REACH_W-1:0]  out_reached_state;
  logic                out_match_found;
  logic [PNUM_W-1:0]   out_pattern_number;

  item_t      pending_items[$];
  match_res_t expected_matches[$];
  int         errors = 0;
  int         stuck_cycles = 0;
  int         idle_mode = 0;
  logic       in_taken = 1'b0;

  // Automaton mirror.
  int   trie_parent[NSTATES];
  logic [7:0] trie_label[NSTATES];
  int   fail_link[NSTATES];
  bit   marked[NSTATES];
  int   mark_num[NSTATES];
  int   node_count, build_pos, pattern_count, scan_pos;

  multi_pattern_automaton_matcher_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int child_node(int p, logic [7:0] c);
    for (int s = 1; s < node_count; s++) begin
      if (trie_parent[s] == p && trie_label[s] == c) return s;
    end
    return 0;
  endfunction

  function automatic int follow_links(int start, logic [7:0] c);
    int st;
    int ch;
    st = start;
    for (int hops = 0; hops <= NSTATES && st >= 0; hops++) begin
      ch = child_node(st, c);
      if (ch != 0) return ch;
      st = fail_link[st];
    end
    return 0;
  endfunction

  function automatic match_res_t advance_automaton(item_t it);
    match_res_t r;
    int ch;
    r = '{ST_OK, '0, 1'b0, '0};
    case (it.op)
      OP_ADD: begin
        ch = child_node(build_pos, it.sym);
        if (ch == 0) begin
          if (node_count >= NSTATES) begin
            r.status = ST_FULL;
          end else begin
            ch = node_count;
            trie_parent[ch] = build_pos;
            trie_label[ch] = it.sym;
            node_count++;
            fail_link[ch] = follow_links(fail_link[build_pos], it.sym);
          end
        end
        if (r.status == ST_OK) build_pos = ch;
        r.reached = build_pos[7:0];
      end
      OP_END: begin
        if (pattern_count >= NPATTERNS) begin
          r.status = ST_EXHAUSTED;
        end else begin
          marked[build_pos] = 1'b1;
          mark_num[build_pos] = pattern_count;
          pattern_count++;
          build_pos = 0;
        end
        r.reached = build_pos[7:0];
      end
      OP_SCAN: begin
        scan_pos = follow_links(scan_pos, it.sym);
        r.reached = scan_pos[7:0];
        if (marked[scan_pos]) begin
          r.found = 1'b1;
          r.pnum = mark_num[scan_pos][5:0];
        end
      end
      default: begin
        scan_pos = 0;
        r.reached = '0;
      end
    endcase
    return r;
  endfunction

  // Driver: a new item goes out at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 &&
            $urandom_range(99) >= (idle_mode == 1 ? 84 : idle_mode == 3 ? 14 : 0)) begin
          in_operation <= pending_items[0].op;
          in_symbol <= pending_items[0].sym;
          in_valid <= 1'b1;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < (idle_mode == 2 ? 84 : idle_mode == 3 ? 14 : 0));
    end
  end

  // Monitor: check results first, then predict the item taken at the same edge.
  always @(posedge clk) begin
    match_res_t want;
    item_t it;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected result status=%0d state=%0d match=%0d num=%0d", $time,
                   out_status, out_reached_state, out_match_found, out_pattern_number);
          errors++;
        end else begin
          want = expected_matches.pop_front();
          if (out_status !== want.status || out_reached_state !== want.reached ||
              out_match_found !== want.found || out_pattern_number !== want.pnum) begin
            $display("%0t: mismatch expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d", $time,
                     want.status, want.reached, want.found, want.pnum, out_status,
                     out_reached_state, out_match_found, out_pattern_number);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        it.op = in_operation;
        it.sym = in_symbol;
        expected_matches.insert(expected_matches.size(), advance_automaton(it));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym);
    item_t it;
    it.op = op;
    it.sym = sym;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [7:0] pick_symbol();
    // Mostly a small alphabet so patterns share prefixes and scans hit them.
    if ($urandom_range(99) < 80) return 8'h61 + 8'($urandom_range(3));
    return 8'($urandom);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_matches.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int n;
    int len;
    for (int s = 0; s < NSTATES; s++) begin
      trie_parent[s] = 0;
      trie_label[s] = '0;
      fail_link[s] = 0;
      marked[s] = 1'b0;
      mark_num[s] = 0;
    end
    fail_link[0] = -1;
    node_count = 1;
    build_pos = 0;
    pattern_count = 0;
    scan_pos = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme bytes, an empty pattern, a repeated pattern, fallback to a marked root.
    push_item(OP_ADD, 8'h00);
    push_item(OP_ADD, 8'hFF);
    push_item(OP_END, 8'hFF);
    push_item(OP_END, 8'h00);
    push_item(OP_ADD, 8'h61);
    push_item(OP_END, 8'h00);
    push_item(OP_ADD, 8'h61);
    push_item(OP_END, 8'hA5);
    push_item(OP_SCAN, 8'h00);
    push_item(OP_SCAN, 8'hFF);
    push_item(OP_SCAN, 8'h42);
    push_item(OP_SCAN, 8'h61);
    push_item(OP_RESTART, 8'h5A);
    push_item(OP_SCAN, 8'hFF);
    push_item(OP_SCAN, 8'h00);
    push_item(OP_RESTART, 8'h00);

    for (int mode = 0; mode < 4; mode++) begin
      wait_drained();
      idle_mode = mode;
      n = 0;
      while (n < 435) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++) push_item(OP_ADD, pick_symbol());
            push_item(OP_END, 8'($urandom));
            n += len + 1;
          end
          4, 5, 6, 7: begin
            len = $urandom_range(20, 4);
            push_item(OP_RESTART, 8'($urandom));
            for (int k = 0; k < len; k++) push_item(OP_SCAN, pick_symbol());
            n += len + 1;
          end
          default: begin
            push_item(OP_W'($urandom), 8'($urandom));
            n++;
          end
        endcase
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
